### src/tkrs_pkg.sv
// Package for the top-k ranked selector: sizes, entry type and rank compare.
package tkrs_pkg;

	localparam int Capacity = 16;
	localparam int IdxW = $clog2(Capacity);
	localparam int CntW = $clog2(Capacity + 1);

	typedef struct packed {
		logic [31:0] score;
		logic [26:0] date;
		logic [47:0] id;
		logic [31:0] name;
	} entry_t;

	localparam int EntryW = $bits(entry_t);

	typedef enum logic {
		KIND_OFFER = 1'b0,
		KIND_READ  = 1'b1
	} kind_t;

	// True when a strictly outranks b
	function automatic logic outranks(entry_t a, entry_t b, logic mode);
		logic r;
		if (a.score != b.score) r = a.score > b.score;
		else if (a.date != b.date) r = a.date > b.date;
		else if (a.id == b.id) r = 1'b0;
		else r = mode ? (a.id > b.id) : (a.id < b.id);
		return r;
	endfunction

endpackage

### src/top_k_ranked_selector_top.sv
// Top level of the top-k ranked selector: table memory, scan and sort sequencer.
//
// The block keeps the best 16 entries offered. One item at a time: start is
// taken only while busy is low. An offer while the table has room is written
// in the accepting cycle, so busy stays low and the next word can follow at
// once. An offer to a full table scans all 16 slots through the one read port
// of the entry memory, reading and then comparing each slot, and then
// decides on the replacement: busy stays high from acceptance until that
// decision. A readout runs an insertion sort in the memory (one read and at
// most one write per cycle) and then streams the n entries, each read and
// then emitted, each marked by out_valid for one cycle; last marks the final
// one. The receiver cannot stall the stream. order_mode is written through
// cfg_valid/cfg_ready.
module top_k_ranked_selector_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [31:0] score,
	input  logic [26:0] date_key,
	input  logic [47:0] id_key,
	input  logic [31:0] name_tag,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	output logic        out_valid,
	output logic [47:0] out_id,
	output logic [31:0] out_name,
	output logic [31:0] out_score,
	output logic        last
);
	import tkrs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_REPL,
		ST_SORT_KEY, ST_SORT_KEYW, ST_SORT_RD, ST_SORT_CMP, ST_SORT_PUT,
		ST_OUT_RD, ST_OUT_EMIT
	} state_t;

	state_t          state_q;
	logic            mode_q;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] i_q;      // scan index / sort outer index
	logic [CntW-1:0] j_q;      // sort inner position
	logic [IdxW-1:0] worst_q;
	entry_t          worst_e_q;
	entry_t          new_q;    // offered entry or sort key

	// entry memory, one port each way, registered read
	entry_t          mem [Capacity];
	logic            we;
	logic [IdxW-1:0] waddr;
	entry_t          wdata;
	logic [IdxW-1:0] raddr;
	entry_t          rdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// read address and write port steering
	always_comb begin
		raddr = i_q[IdxW-1:0];
		we = 1'b0;
		waddr = i_q[IdxW-1:0];
		wdata = new_q;
		unique case (state_q)
			ST_SORT_RD: raddr = IdxW'(j_q - 1'b1);
			ST_SORT_CMP: begin
				we = outranks(new_q, rdata, mode_q);
				waddr = j_q[IdxW-1:0];
				wdata = rdata;
			end
			ST_SORT_PUT: waddr = j_q[IdxW-1:0];
			ST_REPL: begin
				we = outranks(new_q, worst_e_q, mode_q);
				waddr = worst_q;
			end
			default: ;
		endcase
		if (state_q == ST_SORT_PUT) we = 1'b1;
		if (state_q == ST_IDLE && start && kind == KIND_OFFER && count_q < CntW'(Capacity)) begin
			we = 1'b1;
			waddr = count_q[IdxW-1:0];
			wdata = '{score: score, date: date_key, id: id_key, name: name_tag};
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= 1'b0;
			count_q <= '0;
			i_q <= '0;
			j_q <= '0;
			worst_q <= '0;
			out_valid <= 1'b0;
			last <= 1'b0;
		end else begin
			out_valid <= 1'b0;
			last <= 1'b0;
			if (cfg_valid) mode_q <= cfg_data;
			unique case (state_q)
				ST_IDLE: begin
					i_q <= '0;
					if (start) begin
						new_q <= '{score: score, date: date_key, id: id_key, name: name_tag};
						if (kind == KIND_READ) begin
							i_q <= CntW'(1);
							state_q <= ST_SORT_KEY;
						end else if (count_q < CntW'(Capacity)) begin
							count_q <= count_q + 1'b1;
						end else begin
							state_q <= ST_SCAN_RD;
						end
					end
				end
				ST_SCAN_RD: begin
					i_q <= i_q + 1'b1;
					state_q <= ST_SCAN_CMP;
				end
				ST_SCAN_CMP: begin
					// keep the lowest slot among exact ties for worst
					if (i_q == CntW'(1) || outranks(worst_e_q, rdata, mode_q)) begin
						worst_e_q <= rdata;
						worst_q <= IdxW'(i_q - 1'b1);
					end
					state_q <= (i_q == CntW'(Capacity)) ? ST_REPL : ST_SCAN_RD;
				end
				ST_REPL: state_q <= ST_IDLE;
				ST_SORT_KEY: begin
					if (i_q >= count_q) begin
						i_q <= '0;
						state_q <= (count_q == '0) ? ST_IDLE : ST_OUT_RD;
					end else begin
						state_q <= ST_SORT_KEYW;
					end
				end
				ST_SORT_KEYW: begin
					j_q <= i_q;
					state_q <= ST_SORT_RD;
				end
				ST_SORT_RD: begin
					if (j_q == i_q) new_q <= rdata;
					state_q <= (j_q == '0) ? ST_SORT_PUT : ST_SORT_CMP;
				end
				ST_SORT_CMP: begin
					if (outranks(new_q, rdata, mode_q)) begin
						j_q <= j_q - 1'b1;
						state_q <= (j_q == CntW'(1)) ? ST_SORT_PUT : ST_SORT_RD;
					end else begin
						state_q <= ST_SORT_PUT;
					end
				end
				ST_SORT_PUT: begin
					i_q <= i_q + 1'b1;
					state_q <= ST_SORT_KEY;
				end
				ST_OUT_RD: begin
					i_q <= i_q + 1'b1;
					state_q <= ST_OUT_EMIT;
				end
				ST_OUT_EMIT: begin
					out_valid <= 1'b1;
					last <= (i_q == count_q);
					out_id <= rdata.id;
					out_name <= rdata.name;
					out_score <= rdata.score;
					state_q <= (i_q == count_q) ? ST_IDLE : ST_OUT_RD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
